// ----- rtl/pma_pkg.sv -----
package pma_pkg;

    // field prime and derived constants
    localparam logic [29:0] MODULUS    = 30'd1000000007;
    localparam logic [31:0] MODULUS_X2 = 32'd2000000014;
    localparam logic [63:0] FERMAT_EXP = 64'd1000000005;
    localparam logic [63:0] MU_WIDE    = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] BARRETT_MU = MU_WIDE[30:0];
    // 2^30 mod the prime, used to fold high operand bits
    localparam logic [26:0] FOLD_R     = 27'd73741817;

    localparam int PC_W  = 4;
    localparam int CNT_W = 4;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_POW = 3'd3,
        OP_INV = 3'd4,
        OP_DIV = 3'd5
    } t_req_op;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [63:0] operand_a;
        logic signed [63:0] operand_b;
    } t_req;

    typedef struct packed {
        logic [29:0] result;
        logic        exponent_error;
    } t_rsp;

    // datapath operation of one microcode step
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_RED,
        DP_FIX,
        DP_SETUP,
        DP_SETUP_DIV,
        DP_MUL1,
        DP_MUL2,
        DP_MUL3,
        DP_MUL4,
        DP_RES
    } t_dp_op;

    // jump conditions
    typedef enum logic [2:0] {
        JMP_NONE,
        JMP_NO_IN,
        JMP_CNT,
        JMP_EXP_ZERO,
        JMP_EXP_MORE,
        JMP_OUT_BUSY
    } t_jmp;

    typedef struct packed {
        t_dp_op          op;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic exp_zero;
        logic exp_more;
        logic out_busy;
    } t_stat;

    // microprogram rom; the last step falls through to step zero
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword uw;
        uw = '{op: DP_NOP, jmp: JMP_NONE, target: '0};
        case (pc)
            4'd0:  uw = '{op: DP_LOAD,      jmp: JMP_NO_IN,    target: 4'd0};
            4'd1:  uw = '{op: DP_RED,       jmp: JMP_CNT,      target: 4'd1};
            4'd2:  uw = '{op: DP_FIX,       jmp: JMP_NONE,     target: 4'd0};
            4'd3:  uw = '{op: DP_SETUP,     jmp: JMP_NONE,     target: 4'd0};
            4'd4:  uw = '{op: DP_NOP,       jmp: JMP_EXP_ZERO, target: 4'd9};
            4'd5:  uw = '{op: DP_MUL1,      jmp: JMP_NONE,     target: 4'd0};
            4'd6:  uw = '{op: DP_MUL2,      jmp: JMP_NONE,     target: 4'd0};
            4'd7:  uw = '{op: DP_MUL3,      jmp: JMP_NONE,     target: 4'd0};
            4'd8:  uw = '{op: DP_MUL4,      jmp: JMP_EXP_MORE, target: 4'd5};
            4'd9:  uw = '{op: DP_SETUP_DIV, jmp: JMP_NONE,     target: 4'd0};
            4'd10: uw = '{op: DP_NOP,       jmp: JMP_EXP_ZERO, target: 4'd15};
            4'd11: uw = '{op: DP_MUL1,      jmp: JMP_NONE,     target: 4'd0};
            4'd12: uw = '{op: DP_MUL2,      jmp: JMP_NONE,     target: 4'd0};
            4'd13: uw = '{op: DP_MUL3,      jmp: JMP_NONE,     target: 4'd0};
            4'd14: uw = '{op: DP_MUL4,      jmp: JMP_EXP_MORE, target: 4'd11};
            4'd15: uw = '{op: DP_RES,       jmp: JMP_OUT_BUSY, target: 4'd15};
            default: uw = '{op: DP_NOP, jmp: JMP_NONE, target: '0};
        endcase
        return uw;
    endfunction

endpackage

// ----- rtl/pma_mulmod.sv -----
module pma_mulmod (
    input  logic            i_clk,
    input  pma_pkg::t_dp_op i_op,
    input  logic [29:0]     i_x,
    input  logic [29:0]     i_y,
    output logic [29:0]     o_prod
);
    import pma_pkg::*;

    logic [59:0] r_p;
    logic [30:0] r_q;
    logic [31:0] r_qm;

    logic [59:0] w_prod;
    logic [61:0] w_qest;
    logic [60:0] w_qm;
    logic [31:0] w_r;
    logic [31:0] w_r1;
    logic [31:0] w_r2;

    // one multiplier per stage, each registered
    assign w_prod = {30'd0, i_x} * {30'd0, i_y};
    assign w_qest = {31'd0, r_p[59:29]} * {31'd0, BARRETT_MU};
    assign w_qm   = {30'd0, r_q} * {31'd0, MODULUS};

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_MUL1: r_p  <= w_prod;
            DP_MUL2: r_q  <= w_qest[61:31];
            DP_MUL3: r_qm <= w_qm[31:0];
            default: ;
        endcase
    end

    // barrett remainder is below three times the modulus
    assign w_r  = r_p[31:0] - r_qm;
    assign w_r1 = w_r - {2'd0, MODULUS};
    assign w_r2 = w_r - MODULUS_X2;

    always_comb begin
        if (w_r >= MODULUS_X2) begin
            o_prod = w_r2[29:0];
        end else if (w_r >= {2'd0, MODULUS}) begin
            o_prod = w_r1[29:0];
        end else begin
            o_prod = w_r[29:0];
        end
    end

endmodule

// ----- rtl/pma_seq.sv -----
module pma_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pma_pkg::t_stat  i_stat,
    output pma_pkg::t_uword o_uword
);
    import pma_pkg::*;

    logic [PC_W-1:0]  r_pc;
    logic [PC_W-1:0]  n_pc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    t_uword           w_uw;
    logic             w_take;

    assign w_uw    = ucode(r_pc);
    assign o_uword = w_uw;

    // jump condition select
    always_comb begin
        case (w_uw.jmp)
            JMP_NO_IN:    w_take = !i_stat.in_valid;
            JMP_CNT:      w_take = (r_cnt != '1);
            JMP_EXP_ZERO: w_take = i_stat.exp_zero;
            JMP_EXP_MORE: w_take = i_stat.exp_more;
            JMP_OUT_BUSY: w_take = i_stat.out_busy;
            default:      w_take = 1'b0;
        endcase
    end

    // step counter and reduction loop counter
    always_comb begin
        n_pc  = w_take ? w_uw.target : r_pc + PC_W'(1);
        n_cnt = (w_uw.op == DP_RED) ? r_cnt + CNT_W'(1) : r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= '0;
            r_cnt <= '0;
        end else begin
            r_pc  <= n_pc;
            r_cnt <= n_cnt;
        end
    end

endmodule

// ----- rtl/pma_dp.sv -----
module pma_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pma_pkg::t_dp_op i_op,
    input  logic            i_req_valid,
    input  pma_pkg::t_req   i_req,
    output pma_pkg::t_stat  o_stat,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output pma_pkg::t_rsp   o_rsp
);
    import pma_pkg::*;

    t_req_op     r_op;
    logic [63:0] r_mag_a;
    logic [63:0] r_mag_b;
    logic        r_neg_a;
    logic        r_neg_b;
    logic [63:0] r_raw_b;
    logic [29:0] r_ra;
    logic [29:0] r_rb;
    logic [29:0] r_acc;
    logic [29:0] r_base;
    logic [63:0] r_exp;
    logic        r_err;
    t_rsp        r_rsp;
    logic        r_rsp_valid;

    logic [63:0] w_raw_a;
    logic [63:0] w_raw_b;
    logic [29:0] w_mm_acc;
    logic [29:0] w_mm_sq;
    logic [30:0] w_sum;
    logic [29:0] w_res;
    logic        w_busy;

    // fold the bits above 30 back in, 2^30 is congruent to FOLD_R
    function automatic logic [63:0] fold_step(input logic [63:0] x);
        logic [60:0] hi;
        hi = {27'd0, x[63:30]} * {34'd0, FOLD_R};
        return {3'd0, hi} + {34'd0, x[29:0]};
    endfunction

    // fully folded value is below twice the modulus
    function automatic logic [29:0] fold_final(input logic [30:0] x);
        logic [30:0] t;
        t = x;
        if (t >= {1'b0, MODULUS}) begin
            t = t - {1'b0, MODULUS};
        end
        return t[29:0];
    endfunction

    // negative operands wrap upward
    function automatic logic [29:0] fix_sign(input logic [29:0] r, input logic neg);
        logic [29:0] f;
        f = r;
        if (neg && (r != '0)) begin
            f = MODULUS - r;
        end
        return f;
    endfunction

    assign w_raw_a = i_req.operand_a;
    assign w_raw_b = i_req.operand_b;
    assign w_busy  = r_rsp_valid && !i_rsp_ready;

    // shared-round multipliers: acc*base and base*base
    pma_mulmod u_mm_acc (
        .i_clk  (i_clk),
        .i_op   (i_op),
        .i_x    (r_acc),
        .i_y    (r_base),
        .o_prod (w_mm_acc)
    );

    pma_mulmod u_mm_sq (
        .i_clk  (i_clk),
        .i_op   (i_op),
        .i_x    (r_base),
        .i_y    (r_base),
        .o_prod (w_mm_sq)
    );

    // final result select
    assign w_sum = {1'b0, r_ra} + {1'b0, r_rb};
    always_comb begin
        case (r_op)
            OP_ADD:  w_res = (w_sum >= {1'b0, MODULUS}) ? 30'(w_sum - {1'b0, MODULUS})
                                                        : w_sum[29:0];
            OP_SUB:  w_res = (r_ra >= r_rb) ? r_ra - r_rb : r_ra + MODULUS - r_rb;
            OP_MUL,
            OP_POW,
            OP_INV,
            OP_DIV:  w_res = r_acc;
            default: w_res = '0;
        endcase
    end

    // operand and exponentiation registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LOAD: begin
                if (i_req_valid) begin
                    r_op    <= t_req_op'(i_req.req_type);
                    r_neg_a <= w_raw_a[63];
                    r_neg_b <= w_raw_b[63];
                    r_mag_a <= w_raw_a[63] ? ~w_raw_a + 64'd1 : w_raw_a;
                    r_mag_b <= w_raw_b[63] ? ~w_raw_b + 64'd1 : w_raw_b;
                    r_raw_b <= w_raw_b;
                    r_ra    <= '0;
                    r_rb    <= '0;
                end
            end
            DP_RED: begin
                r_mag_a <= fold_step(r_mag_a);
                r_mag_b <= fold_step(r_mag_b);
            end
            DP_FIX: begin
                r_ra <= fix_sign(fold_final(r_mag_a[30:0]), r_neg_a);
                r_rb <= fix_sign(fold_final(r_mag_b[30:0]), r_neg_b);
            end
            DP_SETUP: begin
                case (r_op)
                    OP_MUL: begin
                        r_err  <= 1'b0;
                        r_acc  <= r_ra;
                        r_base <= r_rb;
                        r_exp  <= 64'd1;
                    end
                    OP_POW: begin
                        r_base <= r_ra;
                        if (r_raw_b[63]) begin
                            r_err <= 1'b1;
                            r_acc <= '0;
                            r_exp <= '0;
                        end else begin
                            r_err <= 1'b0;
                            r_acc <= 30'd1;
                            r_exp <= r_raw_b;
                        end
                    end
                    OP_INV: begin
                        r_err  <= 1'b0;
                        r_acc  <= 30'd1;
                        r_base <= r_ra;
                        r_exp  <= FERMAT_EXP;
                    end
                    OP_DIV: begin
                        r_err  <= 1'b0;
                        r_acc  <= 30'd1;
                        r_base <= r_rb;
                        r_exp  <= FERMAT_EXP;
                    end
                    default: begin
                        r_err  <= 1'b0;
                        r_acc  <= '0;
                        r_base <= r_ra;
                        r_exp  <= '0;
                    end
                endcase
            end
            DP_SETUP_DIV: begin
                // divide finishes with one extra round multiplying by a
                if (r_op == OP_DIV) begin
                    r_base <= r_ra;
                    r_exp  <= 64'd1;
                end else begin
                    r_exp <= '0;
                end
            end
            DP_MUL4: begin
                if (r_exp[0]) begin
                    r_acc <= w_mm_acc;
                end
                r_base <= w_mm_sq;
                r_exp  <= r_exp >> 1;
            end
            DP_RES: begin
                if (!w_busy) begin
                    r_rsp <= '{result: w_res, exponent_error: r_err};
                end
            end
            default: ;
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if ((i_op == DP_RES) && !w_busy) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    assign o_rsp_valid     = r_rsp_valid;
    assign o_rsp           = r_rsp;
    assign o_stat.in_valid = i_req_valid;
    assign o_stat.exp_zero = (r_exp == '0);
    assign o_stat.exp_more = |r_exp[63:1];
    assign o_stat.out_busy = w_busy;

endmodule

// ----- rtl/prime_modular_alu.sv -----
// after a folding operand reduction, each square-and-multiply round runs the
// 4-step barrett multiply loop; power takes exponents of up to 63 bits
// throughput: one transaction at a time, next accepted once the result is registered
// reset: synchronous active-low i_rst_n returns the sequencer to its accept step
module prime_modular_alu (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  pma_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output pma_pkg::t_rsp o_rsp
);
    import pma_pkg::*;

    t_uword w_uword;
    t_stat  w_stat;

    // microprogram sequencer
    pma_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_uword (w_uword)
    );

    // arithmetic datapath
    pma_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_uword.op),
        .i_req_valid (i_req_valid),
        .i_req       (i_req),
        .o_stat      (w_stat),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    assign o_req_ready = (w_uword.op == DP_LOAD);

endmodule

// ----- dv/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pma_pkg::*;

    localparam logic [63:0] PRIME     = 64'(MODULUS);
    localparam logic [63:0] FERMAT    = PRIME - 64'd2;
    localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MINUS_ONE = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [2:0]  OP_SPARE6 = 3'd6;
    localparam logic [2:0]  OP_SPARE7 = 3'd7;
    localparam int          RANDOM_REQS = 1250;
    localparam int          DRAIN_EVERY = 250;
    localparam int          TAIL_CYCLES = 400;
    localparam int          MAX_PRINTS  = 100;

    typedef struct {
        t_req req;
        bit   drain_first;
    } t_pending_req;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_req_valid = 1'b0;
    logic  o_req_ready;
    t_req  i_req       = '0;
    logic  o_rsp_valid;
    logic  i_rsp_ready = 1'b0;
    t_rsp  o_rsp;

    t_pending_req pending_req_q[$];
    t_rsp         expected_rsp_q[$];
    t_rsp         oldest_rsp;
    logic         req_taken = 1'b0;
    int           error_count = 0;
    int           burst_left = 0;
    int           gap_left = 0;
    int           stall_run = 0;

    prime_modular_alu u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mathematical remainder of a two's complement value
    function automatic logic [63:0] mod_reduce(input logic [63:0] raw);
        logic [63:0] mag;
        logic [63:0] rem;
        if (!raw[63]) begin
            return raw % PRIME;
        end
        mag = ~raw + 64'd1;
        rem = mag % PRIME;
        return (rem == 64'd0) ? 64'd0 : PRIME - rem;
    endfunction

    // both factors are below the prime, the product fits in 64 bits
    function automatic logic [63:0] mod_mul(input logic [63:0] x, input logic [63:0] y);
        return (x * y) % PRIME;
    endfunction

    // square and multiply over the raw exponent bits
    function automatic logic [63:0] mod_pow(input logic [63:0] base, input logic [63:0] expo);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] e;
        acc = 64'd1;
        sq  = base;
        e   = expo;
        while (e != 64'd0) begin
            if (e[0]) begin
                acc = mod_mul(acc, sq);
            end
            sq = mod_mul(sq, sq);
            e  = e >> 1;
        end
        return acc;
    endfunction

    // expected response of one request
    function automatic t_rsp predict_rsp(input t_req req);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] res;
        logic        err;
        t_rsp        rsp;
        a   = mod_reduce(req.operand_a);
        b   = mod_reduce(req.operand_b);
        res = 64'd0;
        err = 1'b0;
        case (req.req_type)
            OP_ADD: res = (a + b) % PRIME;
            OP_SUB: res = (a >= b) ? (a - b) : (a + PRIME - b);
            OP_MUL: res = mod_mul(a, b);
            OP_POW: begin
                if (req.operand_b[63]) begin
                    err = 1'b1;
                end else begin
                    res = mod_pow(a, req.operand_b);
                end
            end
            OP_INV: res = mod_pow(a, FERMAT);
            OP_DIV: res = mod_mul(a, mod_pow(b, FERMAT));
            default: res = 64'd0;
        endcase
        rsp.result         = res[29:0];
        rsp.exponent_error = err;
        return rsp;
    endfunction

    // operand mix: full range, narrow, tiny, near multiples of the prime, extremes, negated narrow
    function automatic logic [63:0] rand_operand();
        logic [63:0] v;
        case ($urandom_range(0, 5))
            0: v = {$urandom, $urandom};
            1: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: begin
                v = 64'($urandom_range(0, 200));
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            3: begin
                v = 64'($urandom) * PRIME + 64'($urandom_range(0, 4)) - 64'd2;
                if ($urandom_range(0, 1) == 1) v = -v;
            end
            4: begin
                case ($urandom_range(0, 5))
                    0: v = INT64_MAX;
                    1: v = INT64_MIN;
                    2: v = 64'd0;
                    3: v = MINUS_ONE;
                    4: v = PRIME - 64'd1;
                    default: v = PRIME;
                endcase
            end
            default: v = -({$urandom, $urandom} >> $urandom_range(0, 63));
        endcase
        return v;
    endfunction

    // exponents mostly non-negative with a random bit length
    function automatic logic [63:0] rand_exponent();
        logic [63:0] v;
        case ($urandom_range(0, 9))
            0: v = {$urandom, $urandom};
            1: v = -64'($urandom_range(1, 5));
            2: v = 64'($urandom_range(0, 3));
            default: v = {$urandom, $urandom} >> $urandom_range(1, 63);
        endcase
        return v;
    endfunction

    task automatic queue_req(input logic [2:0] op, input logic [63:0] a,
                             input logic [63:0] b, input bit drain);
        t_pending_req item;
        item.req.req_type  = op;
        item.req.operand_a = a;
        item.req.operand_b = b;
        item.drain_first   = drain;
        pending_req_q.insert(pending_req_q.size(), item);
    endtask

    task automatic report_error(input string msg);
        if (error_count < MAX_PRINTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    // request driver: bursts with random gaps, optional drain before an item
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else if (i_req_valid && !req_taken) begin
            // hold until the transaction is taken
        end else if (gap_left != 0) begin
            gap_left    <= gap_left - 1;
            i_req_valid <= 1'b0;
        end else if (pending_req_q.size() == 0 ||
                     (pending_req_q[0].drain_first && expected_rsp_q.size() != 0)) begin
            i_req_valid <= 1'b0;
        end else begin
            i_req       <= pending_req_q[0].req;
            i_req_valid <= 1'b1;
            void'(pending_req_q.pop_front());
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 12);
                case ($urandom_range(0, 3))
                    0: gap_left <= 0;
                    1: gap_left <= $urandom_range(1, 3);
                    2: gap_left <= $urandom_range(1, 40);
                    default: gap_left <= $urandom_range(1, 300);
                endcase
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // response stall pattern: alternating ready runs of random length
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else if (stall_run != 0) begin
            stall_run <= stall_run - 1;
        end else begin
            i_rsp_ready <= !i_rsp_ready;
            if (i_rsp_ready) begin
                case ($urandom_range(0, 3))
                    0: stall_run <= $urandom_range(1, 3);
                    1: stall_run <= $urandom_range(1, 40);
                    2: stall_run <= $urandom_range(1, 150);
                    default: stall_run <= 0;
                endcase
            end else begin
                stall_run <= ($urandom_range(0, 4) == 0) ? $urandom_range(200, 1500)
                                                         : $urandom_range(1, 30);
            end
        end
    end

    // monitor: check responses in order, predict on each accepted request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= i_req_valid && o_req_ready;
            if (o_rsp_valid && i_rsp_ready) begin
                if (expected_rsp_q.size() == 0) begin
                    report_error($sformatf("response with nothing pending: result=%0d err=%0b",
                                           o_rsp.result, o_rsp.exponent_error));
                end else begin
                    oldest_rsp = expected_rsp_q.pop_front();
                    if (o_rsp.result !== oldest_rsp.result) begin
                        report_error($sformatf("result got %0d want %0d",
                                               o_rsp.result, oldest_rsp.result));
                    end
                    if (o_rsp.exponent_error !== oldest_rsp.exponent_error) begin
                        report_error($sformatf("exponent_error got %0b want %0b",
                                               o_rsp.exponent_error,
                                               oldest_rsp.exponent_error));
                    end
                end
            end
            if (i_req_valid && o_req_ready) begin
                expected_rsp_q.insert(expected_rsp_q.size(), predict_rsp(i_req));
            end
        end
    end

    // run limit
    initial begin
        #20_000_000;
        $display("prime_modular_alu verification failed");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        logic [2:0] op;
        int         r;

        // directed: add, subtract and multiply at the operand extremes
        queue_req(OP_ADD, INT64_MAX, INT64_MIN, 1'b0);
        queue_req(OP_ADD, MINUS_ONE, MINUS_ONE, 1'b0);
        queue_req(OP_ADD, PRIME - 64'd1, 64'd1, 1'b0);
        queue_req(OP_SUB, 64'd0, 64'd1, 1'b0);
        queue_req(OP_SUB, INT64_MIN, INT64_MAX, 1'b0);
        queue_req(OP_MUL, MINUS_ONE, MINUS_ONE, 1'b0);
        queue_req(OP_MUL, PRIME - 64'd1, INT64_MIN, 1'b0);
        // zero exponent on base zero, longest and negative exponents
        queue_req(OP_POW, 64'd0, 64'd0, 1'b0);
        queue_req(OP_POW, 64'd2, INT64_MAX, 1'b0);
        queue_req(OP_POW, 64'd3, MINUS_ONE, 1'b0);
        queue_req(OP_POW, INT64_MIN, INT64_MIN, 1'b0);
        queue_req(OP_POW, INT64_MIN, PRIME - 64'd1, 1'b0);
        queue_req(OP_POW, 64'd5, 64'd1, 1'b0);
        // inverse, including values that are zero mod the prime
        queue_req(OP_INV, 64'd0, {$urandom, $urandom}, 1'b0);
        queue_req(OP_INV, PRIME, {$urandom, $urandom}, 1'b0);
        queue_req(OP_INV, 64'd2, {$urandom, $urandom}, 1'b0);
        queue_req(OP_INV, MINUS_ONE, {$urandom, $urandom}, 1'b0);
        // divide, including divisors that are zero mod the prime
        queue_req(OP_DIV, 64'd10, 64'd0, 1'b0);
        queue_req(OP_DIV, 64'd10, PRIME * 64'd3, 1'b0);
        queue_req(OP_DIV, 64'd7, -64'd3, 1'b0);
        queue_req(OP_DIV, INT64_MIN, INT64_MAX, 1'b0);
        // unused opcodes
        queue_req(OP_SPARE6, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        queue_req(OP_SPARE7, MINUS_ONE, MINUS_ONE, 1'b0);

        // random part, with a full drain at the start and every 250 requests
        for (int i = 0; i < RANDOM_REQS; i++) begin
            r = $urandom_range(0, 31);
            op = (r < 30) ? 3'(r % 6) : ((r == 30) ? OP_SPARE6 : OP_SPARE7);
            queue_req(op, rand_operand(),
                      (op == OP_POW) ? rand_exponent() : rand_operand(),
                      (i % DRAIN_EVERY) == 0);
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_req_q.size() != 0 || i_req_valid) @(posedge i_clk);
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("prime_modular_alu verification clean");
        end else begin
            $display("prime_modular_alu verification failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pma_pkg.sv
rtl/pma_mulmod.sv
rtl/pma_seq.sv
rtl/pma_dp.sv
rtl/prime_modular_alu.sv
dv/tb.sv
